/* rtl/nmit_pkg.sv */
`default_nettype none
package nmit_pkg;

  localparam int FRAC_BITS = 16;
  localparam int EW = 32;
  localparam int PW = 2 * EW;
  localparam int CW = PW + 1;
  localparam int MW = PW;
  localparam int DSW = CW + EW + 2;
  localparam int DW = DSW - 1;
  localparam int QB = 34;
  localparam int NW = MW + 2 * FRAC_BITS + 1;
  localparam int WW = (NW > DW + QB) ? NW : DW + QB;

  localparam logic [EW-1:0] SAT_POS = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] SAT_NEG = {1'b1, {(EW-1){1'b0}}};

  typedef struct packed {
    logic [WW-1:0] rem;
    logic [QB-1:0] q;
    logic          neg;
    logic          sat;
  } lane_t;

  typedef struct packed {
    logic          sing;
    logic [WW-1:0] dsh;
    lane_t [8:0]   lane;
  } pkt_t;

endpackage
`default_nettype wire

/* rtl/normal_matrix_inverse_transpose_core.sv */
`default_nettype none
// Channel | Signals                              | Direction
// in      | in_valid, in_stall, a00 .. a22        | matrix beat into core
// out     | out_valid, out_stall, n00 .. n22, singular | result beat out of core
//
// One matrix accepted per cycle while the output is not stalled; the pipeline has 5 cofactor
// and determinant stages, 34 restoring divide steps and 1 round/saturate stage.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output beat freezes the whole pipeline; in_stall follows it.
module normal_matrix_inverse_transpose_core import nmit_pkg::*; (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire signed [31:0] a00,
  input  wire signed [31:0] a01,
  input  wire signed [31:0] a02,
  input  wire signed [31:0] a10,
  input  wire signed [31:0] a11,
  input  wire signed [31:0] a12,
  input  wire signed [31:0] a20,
  input  wire signed [31:0] a21,
  input  wire signed [31:0] a22,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [31:0] n00,
  output logic signed [31:0] n01,
  output logic signed [31:0] n02,
  output logic signed [31:0] n10,
  output logic signed [31:0] n11,
  output logic signed [31:0] n12,
  output logic signed [31:0] n20,
  output logic signed [31:0] n21,
  output logic signed [31:0] n22,
  output logic              singular
);

  localparam int PX [9] = '{4, 3, 3, 1, 0, 0, 1, 0, 0};
  localparam int PY [9] = '{8, 8, 7, 8, 8, 7, 5, 5, 4};
  localparam int UX [9] = '{5, 5, 4, 2, 2, 1, 2, 2, 1};
  localparam int UY [9] = '{7, 6, 6, 7, 6, 6, 4, 3, 3};
  localparam logic [8:0] FLIP = 9'h0AA;

  logic en;
  logic [4:0] vp;
  logic signed [EW-1:0] a [9];
  logic signed [PW-1:0] pp [9];
  logic signed [PW-1:0] pq [9];
  logic signed [EW-1:0] r1 [3];
  logic signed [EW-1:0] r2 [3];
  logic signed [CW-1:0] cof [9];
  logic signed [CW-1:0] cabs [9];
  logic signed [CW-1:0] dif [9];
  logic [MW-1:0] cmag3 [9];
  logic [MW-1:0] cmag4 [9];
  logic [8:0] cneg3;
  logic [8:0] cneg4;
  logic signed [CW-1:0] plo [3];
  logic signed [CW-1:0] phi [3];
  logic signed [DSW-1:0] dsum;
  logic signed [DSW-1:0] d;
  logic signed [DSW-1:0] dabs;
  logic [DW-1:0] dmag;
  logic dneg;
  pkt_t p5_next;
  pkt_t sp0;
  pkt_t sp [QB+1];
  logic [QB:0] sv;
  logic [QB:0] qs [9];
  logic [QB-1:0] qr [9];
  logic [EW-1:0] res [9];
  logic [EW-1:0] nr [9];

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  assign a[0] = a00;
  assign a[1] = a01;
  assign a[2] = a02;
  assign a[3] = a10;
  assign a[4] = a11;
  assign a[5] = a12;
  assign a[6] = a20;
  assign a[7] = a21;
  assign a[8] = a22;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vp <= {vp[3:0], in_valid};
      out_valid <= sv[QB];
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      dif[i] = CW'(pp[i]) - CW'(pq[i]);
      cabs[i] = cof[i][CW-1] ? -cof[i] : cof[i];
    end
    dsum = '0;
    for (int j = 0; j < 3; j++) begin
      dsum = dsum + (DSW'(phi[j]) <<< EW) + DSW'(plo[j]);
    end
    dneg = d[DSW-1];
    dabs = dneg ? -d : d;
    dmag = dabs[DW-1:0];
    p5_next.sing = (d == '0);
    p5_next.dsh = WW'(dmag) << (QB - 1);
    for (int i = 0; i < 9; i++) begin
      p5_next.lane[i].rem = WW'({cmag4[i], {(2 * FRAC_BITS + 1){1'b0}}});
      p5_next.lane[i].q = '0;
      p5_next.lane[i].neg = cneg4[i] ^ dneg;
      p5_next.lane[i].sat = WW'({cmag4[i], {(2 * FRAC_BITS + 1){1'b0}}}) >=
                            (WW'(dmag) << QB);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        pp[i] <= a[PX[i]] * a[PY[i]];
        pq[i] <= a[UX[i]] * a[UY[i]];
        cof[i] <= FLIP[i] ? -dif[i] : dif[i];
        cmag3[i] <= cabs[i][MW-1:0];
        cneg3[i] <= cof[i][CW-1];
        cmag4[i] <= cmag3[i];
        cneg4[i] <= cneg3[i];
      end
      for (int j = 0; j < 3; j++) begin
        r1[j] <= a[j];
        r2[j] <= r1[j];
        plo[j] <= $signed({1'b0, cof[j][EW-1:0]}) * r2[j];
        phi[j] <= $signed(cof[j][CW-1:EW]) * r2[j];
      end
      d <= dsum;
      sp0 <= p5_next;
    end
  end

  assign sv[0] = vp[4];
  assign sp[0] = sp0;

  for (genvar k = 0; k < QB; k++) begin : g_step
    nmit_div_step u_step (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .vi  (sv[k]),
      .pi  (sp[k]),
      .vo  (sv[k+1]),
      .po  (sp[k+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      qs[i] = {1'b0, sp[QB].lane[i].q} + (QB+1)'(1);
      qr[i] = qs[i][QB:1];
      if (sp[QB].sing) begin
        res[i] = '0;
      end else if (sp[QB].lane[i].neg) begin
        if (sp[QB].lane[i].sat || qr[i][QB-1:EW] != '0 ||
            (qr[i][EW-1] && qr[i][EW-2:0] != '0)) begin
          res[i] = SAT_NEG;
        end else begin
          res[i] = -qr[i][EW-1:0];
        end
      end else begin
        if (sp[QB].lane[i].sat || qr[i][QB-1:EW-1] != '0) begin
          res[i] = SAT_POS;
        end else begin
          res[i] = qr[i][EW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        nr[i] <= res[i];
      end
      singular <= sp[QB].sing;
    end
  end

  assign n00 = nr[0];
  assign n01 = nr[1];
  assign n02 = nr[2];
  assign n10 = nr[3];
  assign n11 = nr[4];
  assign n12 = nr[5];
  assign n20 = nr[6];
  assign n21 = nr[7];
  assign n22 = nr[8];

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && singular) |-> (n00 == 0 && n11 == 0 && n22 == 0 && n12 == 0))
    else $error("singular beat with nonzero entry");

  a_stall_link: assert property (@(posedge clk)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && vp == '0))
    else $error("valid bits survive reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!en) |=> ($stable(vp) && $stable(sv)))
    else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

/* rtl/nmit_div_step.sv */
`default_nettype none
module nmit_div_step import nmit_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  input  wire  en,
  input  wire  vi,
  input  pkt_t pi,
  output logic vo,
  output pkt_t po
);

  pkt_t pn;

  always_comb begin
    pn = pi;
    pn.dsh = pi.dsh >> 1;
    for (int i = 0; i < 9; i++) begin
      if (pi.lane[i].rem >= pi.dsh) begin
        pn.lane[i].rem = pi.lane[i].rem - pi.dsh;
        pn.lane[i].q = {pi.lane[i].q[QB-2:0], 1'b1};
      end else begin
        pn.lane[i].q = {pi.lane[i].q[QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      po <= pn;
    end
  end

endmodule
`default_nettype wire

/* test/normal_matrix_inverse_transpose_core_tb.sv */
`default_nettype none
module normal_matrix_inverse_transpose_core_tb;
  import nmit_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] a [9];
    bit          hold;
  } matrix_t;

  typedef struct {
    logic [31:0] n [9];
    logic        sing;
  } normal_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid, singular;
  logic [31:0] ain [9] = '{default: '0};
  logic [31:0] got [9];
  logic signed [31:0] n00, n01, n02, n10, n11, n12, n20, n21, n22;

  matrix_t matrix_q [$];
  normal_t normal_q [$];
  int errors = 0;
  int sent = 0;
  int cycles = 0;
  int idle_pct = 26;
  int stall_pct = 68;

  normal_matrix_inverse_transpose_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .a00(ain[0]), .a01(ain[1]), .a02(ain[2]),
    .a10(ain[3]), .a11(ain[4]), .a12(ain[5]),
    .a20(ain[6]), .a21(ain[7]), .a22(ain[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .n00(n00), .n01(n01), .n02(n02), .n10(n10), .n11(n11), .n12(n12),
    .n20(n20), .n21(n21), .n22(n22), .singular(singular)
  );

  assign got[0] = n00; assign got[1] = n01; assign got[2] = n02;
  assign got[3] = n10; assign got[4] = n11; assign got[5] = n12;
  assign got[6] = n20; assign got[7] = n21; assign got[8] = n22;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic normal_t normal_of(logic [31:0] a [9]);
    logic signed [127:0] e [9];
    logic signed [127:0] c [9];
    logic signed [127:0] det;
    logic [127:0] dm, cm, num, q, r;
    logic neg;
    normal_t res;
    for (int i = 0; i < 9; i++) e[i] = {{96{a[i][31]}}, a[i]};
    c[0] = e[4] * e[8] - e[5] * e[7];
    c[1] = -(e[3] * e[8] - e[5] * e[6]);
    c[2] = e[3] * e[7] - e[4] * e[6];
    c[3] = -(e[1] * e[8] - e[2] * e[7]);
    c[4] = e[0] * e[8] - e[2] * e[6];
    c[5] = -(e[0] * e[7] - e[1] * e[6]);
    c[6] = e[1] * e[5] - e[2] * e[4];
    c[7] = -(e[0] * e[5] - e[2] * e[3]);
    c[8] = e[0] * e[4] - e[1] * e[3];
    det = e[0] * c[0] + e[1] * c[1] + e[2] * c[2];
    res.sing = (det == 0);
    dm = (det < 0) ? -det : det;
    for (int i = 0; i < 9; i++) begin
      res.n[i] = '0;
      if (det != 0 && c[i] != 0) begin
        cm = (c[i] < 0) ? -c[i] : c[i];
        num = cm << (2 * FRAC_BITS);
        q = num / dm;
        r = num % dm;
        if ((r << 1) >= dm) q = q + 1;
        neg = (c[i] < 0) != (det < 0);
        if (neg) res.n[i] = (q > 128'h8000_0000) ? SAT_NEG : -q[31:0];
        else res.n[i] = (q > 128'h7FFF_FFFF) ? SAT_POS : q[31:0];
      end
    end
    return res;
  endfunction

  task automatic report(input string what, input logic [31:0] g, input logic [31:0] x);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, g, x, $realtime);
  endtask

  function automatic logic [31:0] pick_entry(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      2: return 32'($urandom_range(0, 64)) - 32'd32;
      default: begin
        case ($urandom_range(0, 6))
          0: return '0;
          1: return ONE;
          2: return -ONE;
          3: return SAT_POS;
          4: return SAT_NEG;
          5: return 32'd1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  task automatic add_matrix(input logic [31:0] a [9], input bit hold = 0);
    matrix_t m;
    m.a = a;
    m.hold = hold;
    matrix_q.push_back(m);
  endtask

  function automatic matrix_t random_matrix();
    matrix_t m;
    int kind, src, dst;
    kind = $urandom_range(0, 9);
    m.hold = 0;
    for (int i = 0; i < 9; i++) begin
      if (kind <= 2) m.a[i] = pick_entry(0);
      else if (kind <= 5) m.a[i] = pick_entry(1);
      else if (kind == 6) m.a[i] = pick_entry(2);
      else if (kind == 7) m.a[i] = pick_entry($urandom_range(0, 3));
      else m.a[i] = pick_entry(1);
    end
    if (kind == 8) begin
      src = $urandom_range(0, 2);
      dst = (src + $urandom_range(1, 2)) % 3;
      for (int j = 0; j < 3; j++) m.a[3 * dst + j] = m.a[3 * src + j];
    end else if (kind == 9) begin
      for (int i = 0; i < 9; i++)
        m.a[i] = (i % 4 == 0) ? 32'($urandom_range(1, 8)) : 32'd0;
    end
    return m;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        normal_q.push_back(normal_of(ain));
        sent++;
      end
      if (!in_valid || !in_stall) begin
        if (matrix_q.size() > 0 && !(matrix_q[0].hold && (normal_q.size() > 0 ||
            (in_valid && !in_stall))) && $urandom_range(0, 99) >= idle_pct) begin
          ain <= matrix_q[0].a;
          in_valid <= 1'b1;
          void'(matrix_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    normal_t x;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (normal_q.size() == 0) begin
          report("unexpected beat", got[0], '0);
        end else begin
          x = normal_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (got[i] !== x.n[i]) report($sformatf("n%0d%0d", i / 3, i % 3), got[i], x.n[i]);
          if (singular !== x.sing) report("singular", 32'(singular), 32'(x.sing));
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (sent < 280) begin
      idle_pct <= 26; stall_pct <= 68;
    end else if (sent < 560) begin
      idle_pct <= 68; stall_pct <= 26;
    end else begin
      idle_pct <= 0; stall_pct <= 0;
    end
  end

  initial begin
    matrix_t m;
    add_matrix('{default: '0});
    add_matrix('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
    add_matrix('{-ONE, 0, 0, 0, ONE << 1, 0, 0, 0, ONE >> 1});
    add_matrix('{SAT_POS, 0, 0, 0, SAT_POS, 0, 0, 0, SAT_POS});
    add_matrix('{SAT_NEG, 0, 0, 0, SAT_NEG, 0, 0, 0, SAT_NEG});
    add_matrix('{SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, SAT_POS, SAT_NEG,
                 SAT_NEG, SAT_NEG, SAT_POS});
    add_matrix('{SAT_POS, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS, SAT_POS,
                 SAT_POS, SAT_POS, SAT_NEG});
    add_matrix('{32'd1, 0, 0, 0, 32'd1, 0, 0, 0, 32'd1});
    add_matrix('{32'hFFFF_FFFF, 0, 0, 0, 32'd1, 0, 0, 0, 32'd1});
    add_matrix('{32'd3, 0, 0, 0, 32'd3, 0, 0, 0, 32'd3});
    add_matrix('{32'd2, 32'd1, 0, 32'd1, 32'd2, 0, 0, 0, 32'd3});
    add_matrix('{ONE, ONE << 1, ONE * 3, ONE * 4, ONE * 5, ONE * 6,
                 ONE * 7, ONE * 8, ONE * 9});
    add_matrix('{ONE, 0, 0, ONE, 0, 0, 0, 0, ONE});
    add_matrix('{0, ONE, 0, ONE, 0, 0, 0, 0, ONE});
    add_matrix('{ONE << 4, ONE, 0, 0, ONE << 4, 0, 0, 0, 32'd1});
    add_matrix('{32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
                 32'h8765_4321, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h7FFF_0001,
                 32'h8000_FFFE}, 1);
    for (int k = 0; k < 850; k++) begin
      m = random_matrix();
      m.hold = (k == 400 || k == 700);
      matrix_q.push_back(m);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (matrix_q.size() == 0 && !in_valid);
    wait (normal_q.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && normal_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* normal_matrix_inverse_transpose_core.f */
rtl/nmit_pkg.sv
rtl/nmit_div_step.sv
rtl/normal_matrix_inverse_transpose_core.sv
test/normal_matrix_inverse_transpose_core_tb.sv
